// ----- rtl/core/wts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package wts_pkg;

  localparam int RING_DEPTH = 64;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int FILL_W     = IDX_W + 1;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_W      = 40;
  localparam int MARK_W     = TIME_W + COUNT_W;
  localparam int ADDR_W     = IDX_W + 1;

  // accumulator widths
  localparam int S1_W  = COUNT_W + IDX_W;
  localparam int SQ_W  = 2 * COUNT_W;
  localparam int S2_W  = SQ_W + IDX_W;
  localparam int ACC_W = S2_W + FILL_W;

  // divider and square root widths
  localparam int DIV_W      = ACC_W + 2 * FRAC_BITS;
  localparam int DEN_W      = 2 * IDX_W;
  localparam int DCNT_W     = $clog2(DIV_W + 1);
  localparam int SQRT_IN_W  = DIV_W + (DIV_W % 2);
  localparam int ROOT_W     = SQRT_IN_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SCNT_W     = $clog2(ROOT_W + 1);

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAN = 2'd1;
  localparam logic [1:0] OP_STATS = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_DROPPED  = 2'd1;
  localparam logic [1:0] STS_ZERO_WIN = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_CL_RD, S_CL_CHK, S_CL_FIN, S_ST_RD, S_ST_CHK, S_ST_ACC,
    S_ST_POST, S_MEAN_GO, S_MEAN_WAIT, S_VAR_NS2, S_VAR_SQ, S_VAR_GO,
    S_VAR_WAIT, S_SQRT, S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic [OUT_W-1:0] sat_out(input logic [DIV_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (v[DIV_W-1:OUT_W] != '0) r = '1;
    else r = v[OUT_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/wts_mark_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wts_mark_ram (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [wts_pkg::ADDR_W-1:0]  wr_addr,
  input  wire logic [wts_pkg::MARK_W-1:0]  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [wts_pkg::ADDR_W-1:0]  rd_addr,
  output logic      [wts_pkg::MARK_W-1:0]  rd_data
);

  logic [wts_pkg::MARK_W-1:0] mem_r [2**wts_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/wts_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wts_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [wts_pkg::DIV_W-1:0]  dividend,
  input  wire logic [wts_pkg::DEN_W-1:0]  divisor,
  output wts_pkg::unit_sts_t              sts,
  output logic      [wts_pkg::DIV_W-1:0]  quotient
);

  logic [wts_pkg::DIV_W-1:0]  q_r;
  logic [wts_pkg::DEN_W-1:0]  r_r;
  logic [wts_pkg::DEN_W-1:0]  d_r;
  logic [wts_pkg::DCNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [wts_pkg::DEN_W:0]    trial;
  logic [wts_pkg::DEN_W:0]    diff;
  logic                       ge;
  logic                       last;

  // one restoring step per cycle, msb first
  assign trial = {r_r, q_r[wts_pkg::DIV_W-1]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};
  assign last  = busy_r && cnt_r == wts_pkg::DCNT_W'(wts_pkg::DIV_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      r_r   <= '0;
      d_r   <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[wts_pkg::DIV_W-2:0], ge};
      r_r   <= ge ? diff[wts_pkg::DEN_W-1:0] : trial[wts_pkg::DEN_W-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

// ----- rtl/core/wts_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
module wts_isqrt (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [wts_pkg::SQRT_IN_W-1:0]  radicand,
  output wts_pkg::unit_sts_t                  sts,
  output logic      [wts_pkg::ROOT_W-1:0]     root
);

  logic [wts_pkg::SQRT_IN_W-1:0] v_r;
  logic [wts_pkg::REM_W-1:0]     rem_r;
  logic [wts_pkg::ROOT_W-1:0]    root_r;
  logic [wts_pkg::SCNT_W-1:0]    cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [wts_pkg::REM_W-1:0]     rem_sh;
  logic [wts_pkg::REM_W-1:0]     trial;
  logic                          ge;
  logic                          last;

  // two radicand bits per step, one root bit out
  assign rem_sh = {rem_r[wts_pkg::REM_W-3:0], v_r[wts_pkg::SQRT_IN_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign last   = busy_r && cnt_r == wts_pkg::SCNT_W'(wts_pkg::ROOT_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[wts_pkg::SQRT_IN_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[wts_pkg::ROOT_W-2:0], ge};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = root_r;

endmodule
`default_nettype wire

// ----- rtl/core/windowed_transfer_statistics.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake            payload
// in_       input      in_valid / in_ready  opcode, direction, now, bytes, window
// out_      output     out_valid/out_ready  status, counts, fill, mean, deviation
//
// add writes the mark directly; clean reads and checks marks from the oldest end, then
// updates the ring; statistics read, compare and square-accumulate each mark in the
// window, then run a serial division for the mean, a shift-add pass (n*s2 minus s1*s1),
// a second division and a square root, on the bit-serial divider and sqrt units
// reset clears ring pointers and fill counts; mark ram contents are undefined
// in_ready is high only while idle; a finished word waits in the output register
module windowed_transfer_statistics (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_opcode,
  input  wire logic                        in_direction,
  input  wire logic [31:0]                 in_now_seconds,
  input  wire logic [31:0]                 in_byte_count,
  input  wire logic [31:0]                 in_window_seconds,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_status,
  output logic [wts_pkg::FILL_W-1:0]       out_entries_counted,
  output logic [wts_pkg::FILL_W-1:0]       out_fill_level,
  output logic [wts_pkg::OUT_W-1:0]        out_mean_bytes,
  output logic [wts_pkg::OUT_W-1:0]        out_deviation_bytes
);

  wts_pkg::state_t state_r, state_nxt;

  // latched request word
  logic [1:0]                  op_r;
  logic                        dir_r;
  logic [wts_pkg::TIME_W-1:0]  now_r;
  logic [wts_pkg::COUNT_W-1:0] bytes_r;
  logic [wts_pkg::TIME_W-1:0]  win_r;

  // ring bookkeeping, one entry per direction
  logic [wts_pkg::IDX_W-1:0]   oldest_r [2];
  logic [wts_pkg::FILL_W-1:0]  fill_r   [2];

  // walk and arithmetic state
  logic [wts_pkg::FILL_W-1:0]  cnt_r;
  logic [wts_pkg::S1_W-1:0]    s1_r;
  logic [wts_pkg::S2_W-1:0]    s2_r;
  logic [wts_pkg::SQ_W-1:0]    prod_r;
  logic [wts_pkg::ACC_W-1:0]   acc_r;
  logic [wts_pkg::ACC_W-1:0]   mc_r;
  logic [wts_pkg::S1_W-1:0]    mp_r;
  logic [1:0]                  status_r;
  logic [wts_pkg::OUT_W-1:0]   mean_r;
  logic [wts_pkg::OUT_W-1:0]   dev_r;

  // output register
  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [wts_pkg::FILL_W-1:0]  out_entries_r;
  logic [wts_pkg::FILL_W-1:0]  out_fill_r;
  logic [wts_pkg::OUT_W-1:0]   out_mean_r;
  logic [wts_pkg::OUT_W-1:0]   out_dev_r;

  logic [wts_pkg::IDX_W-1:0]   cur_oldest;
  logic [wts_pkg::FILL_W-1:0]  cur_fill;
  logic                        full;
  logic [wts_pkg::IDX_W-1:0]   add_oldest;
  logic [wts_pkg::FILL_W-1:0]  add_fill;
  logic [wts_pkg::IDX_W-1:0]   wr_slot;
  logic [wts_pkg::IDX_W-1:0]   rd_slot;
  logic [wts_pkg::MARK_W-1:0]  rd_data;
  logic [wts_pkg::TIME_W-1:0]  mark_time;
  logic [wts_pkg::COUNT_W-1:0] mark_bytes;
  logic [wts_pkg::TIME_W-1:0]  age;
  logic                        walk_end;
  logic [wts_pkg::ACC_W-1:0]   addsub;
  logic [wts_pkg::FILL_W-1:0]  cnt_m1;
  logic [2*wts_pkg::FILL_W-1:0] den_full;
  logic [wts_pkg::DIV_W-1:0]   div_dividend;
  logic [wts_pkg::DEN_W-1:0]   div_divisor;
  logic [wts_pkg::DIV_W-1:0]   div_q;
  logic [wts_pkg::ROOT_W-1:0]  sq_root;
  wts_pkg::unit_sts_t          div_sts;
  wts_pkg::unit_sts_t          sqrt_sts;
  logic                        ram_wr_en;
  logic                        ram_rd_en;
  logic                        div_start;
  logic                        sqrt_start;
  logic                        out_free;

  assign cur_oldest = oldest_r[dir_r];
  assign cur_fill   = fill_r[dir_r];

  // add: drop oldest first when the ring is full
  assign full       = cur_fill >= wts_pkg::FILL_W'(wts_pkg::RING_DEPTH);
  assign add_oldest = full ? cur_oldest + 1'b1 : cur_oldest;
  assign add_fill   = full ? wts_pkg::FILL_W'(wts_pkg::RING_DEPTH - 1) : cur_fill;
  assign wr_slot    = add_oldest + add_fill[wts_pkg::IDX_W-1:0];

  // clean walks from the oldest end, statistics from the newest end
  always_comb begin
    if (state_r == wts_pkg::S_CL_RD) begin
      rd_slot = cur_oldest + cnt_r[wts_pkg::IDX_W-1:0];
    end else begin
      rd_slot = cur_oldest + cur_fill[wts_pkg::IDX_W-1:0] - 1'b1
                - cnt_r[wts_pkg::IDX_W-1:0];
    end
  end

  assign mark_time  = rd_data[wts_pkg::MARK_W-1 -: wts_pkg::TIME_W];
  assign mark_bytes = rd_data[wts_pkg::COUNT_W-1:0];
  assign age        = (now_r >= mark_time) ? now_r - mark_time : '0;
  assign walk_end   = cnt_r == cur_fill;

  // shared shift-add unit: n*s2 then minus s1*s1
  assign addsub = (state_r == wts_pkg::S_VAR_SQ) ? acc_r - mc_r : acc_r + mc_r;

  assign cnt_m1   = cnt_r - 1'b1;
  assign den_full = {{wts_pkg::FILL_W{1'b0}}, cnt_r} * {{wts_pkg::FILL_W{1'b0}}, cnt_m1};

  always_comb begin
    if (state_r == wts_pkg::S_MEAN_GO) begin
      div_dividend = wts_pkg::DIV_W'(s1_r) << wts_pkg::FRAC_BITS;
      div_divisor  = wts_pkg::DEN_W'(cnt_r);
    end else begin
      div_dividend = {acc_r, {(2*wts_pkg::FRAC_BITS){1'b0}}};
      div_divisor  = den_full[wts_pkg::DEN_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_ready;

  wts_mark_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr ({dir_r, wr_slot}),
    .wr_data ({now_r, bytes_r}),
    .rd_en   (ram_rd_en),
    .rd_addr ({dir_r, rd_slot}),
    .rd_data (rd_data)
  );

  wts_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quotient (div_q)
  );

  wts_isqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (wts_pkg::SQRT_IN_W'(div_q)),
    .sts      (sqrt_sts),
    .root     (sq_root)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wts_pkg::S_IDLE: begin
        if (in_valid) state_nxt = wts_pkg::S_EXEC;
      end
      wts_pkg::S_EXEC: begin
        unique case (op_r)
          wts_pkg::OP_CLEAN: begin
            state_nxt = (win_r == '0) ? wts_pkg::S_CL_FIN : wts_pkg::S_CL_RD;
          end
          wts_pkg::OP_STATS: begin
            state_nxt = (win_r == '0) ? wts_pkg::S_DONE : wts_pkg::S_ST_RD;
          end
          default: state_nxt = wts_pkg::S_DONE;
        endcase
      end
      wts_pkg::S_CL_RD:   state_nxt = walk_end ? wts_pkg::S_CL_FIN : wts_pkg::S_CL_CHK;
      wts_pkg::S_CL_CHK:  state_nxt = (age >= win_r) ? wts_pkg::S_CL_RD : wts_pkg::S_CL_FIN;
      wts_pkg::S_CL_FIN:  state_nxt = wts_pkg::S_DONE;
      wts_pkg::S_ST_RD:   state_nxt = walk_end ? wts_pkg::S_ST_POST : wts_pkg::S_ST_CHK;
      wts_pkg::S_ST_CHK:  state_nxt = (age > win_r) ? wts_pkg::S_ST_POST : wts_pkg::S_ST_ACC;
      wts_pkg::S_ST_ACC:  state_nxt = wts_pkg::S_ST_RD;
      wts_pkg::S_ST_POST: state_nxt = (cnt_r == '0) ? wts_pkg::S_DONE : wts_pkg::S_MEAN_GO;
      wts_pkg::S_MEAN_GO: state_nxt = wts_pkg::S_MEAN_WAIT;
      wts_pkg::S_MEAN_WAIT: begin
        if (div_sts.done) begin
          state_nxt = (cnt_r > wts_pkg::FILL_W'(1)) ? wts_pkg::S_VAR_NS2 : wts_pkg::S_DONE;
        end
      end
      wts_pkg::S_VAR_NS2: if (mp_r == '0) state_nxt = wts_pkg::S_VAR_SQ;
      wts_pkg::S_VAR_SQ:  if (mp_r == '0) state_nxt = wts_pkg::S_VAR_GO;
      wts_pkg::S_VAR_GO:  state_nxt = wts_pkg::S_VAR_WAIT;
      wts_pkg::S_VAR_WAIT: if (div_sts.done) state_nxt = wts_pkg::S_SQRT;
      wts_pkg::S_SQRT:    if (sqrt_sts.done) state_nxt = wts_pkg::S_DONE;
      wts_pkg::S_DONE:    if (out_free) state_nxt = wts_pkg::S_IDLE;
      default:            state_nxt = wts_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready   = state_r == wts_pkg::S_IDLE;
    ram_wr_en  = (state_r == wts_pkg::S_EXEC) && (op_r == wts_pkg::OP_ADD);
    ram_rd_en  = (state_r == wts_pkg::S_CL_RD) || (state_r == wts_pkg::S_ST_RD);
    div_start  = (state_r == wts_pkg::S_MEAN_GO) || (state_r == wts_pkg::S_VAR_GO);
    sqrt_start = (state_r == wts_pkg::S_VAR_WAIT) && div_sts.done;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wts_pkg::S_IDLE;
      oldest_r[0] <= '0;
      oldest_r[1] <= '0;
      fill_r[0]   <= '0;
      fill_r[1]   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_wr_en) begin
        oldest_r[dir_r] <= add_oldest;
        fill_r[dir_r]   <= add_fill + 1'b1;
      end else if (state_r == wts_pkg::S_CL_FIN) begin
        oldest_r[dir_r] <= cur_oldest + cnt_r[wts_pkg::IDX_W-1:0];
        fill_r[dir_r]   <= cur_fill - cnt_r;
      end
      if (state_r == wts_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      wts_pkg::S_IDLE: begin
        if (in_valid) begin
          op_r    <= in_opcode;
          dir_r   <= in_direction;
          now_r   <= in_now_seconds;
          bytes_r <= in_byte_count;
          win_r   <= in_window_seconds;
        end
      end
      wts_pkg::S_EXEC: begin
        mean_r <= '0;
        dev_r  <= '0;
        s1_r   <= '0;
        s2_r   <= '0;
        // dropped mark on a full add, zero window on statistics
        if (op_r == wts_pkg::OP_ADD && full) begin
          status_r <= wts_pkg::STS_DROPPED;
        end else if (op_r == wts_pkg::OP_STATS && win_r == '0) begin
          status_r <= wts_pkg::STS_ZERO_WIN;
        end else begin
          status_r <= wts_pkg::STS_OK;
        end
        // zero-window clean removes the whole ring
        if (op_r == wts_pkg::OP_CLEAN && win_r == '0) begin
          cnt_r <= cur_fill;
        end else begin
          cnt_r <= '0;
        end
      end
      wts_pkg::S_CL_CHK: begin
        if (age >= win_r) cnt_r <= cnt_r + 1'b1;
      end
      wts_pkg::S_ST_CHK: begin
        if (age <= win_r) begin
          s1_r   <= s1_r + wts_pkg::S1_W'(mark_bytes);
          prod_r <= mark_bytes * mark_bytes;
          cnt_r  <= cnt_r + 1'b1;
        end
      end
      wts_pkg::S_ST_ACC: begin
        s2_r <= s2_r + wts_pkg::S2_W'(prod_r);
      end
      wts_pkg::S_MEAN_WAIT: begin
        if (div_sts.done) begin
          mean_r <= wts_pkg::sat_out(div_q);
          acc_r  <= '0;
          mc_r   <= wts_pkg::ACC_W'(s2_r);
          mp_r   <= wts_pkg::S1_W'(cnt_r);
        end
      end
      wts_pkg::S_VAR_NS2: begin
        if (mp_r == '0) begin
          mc_r <= wts_pkg::ACC_W'(s1_r);
          mp_r <= s1_r;
        end else begin
          if (mp_r[0]) acc_r <= addsub;
          mc_r <= mc_r << 1;
          mp_r <= mp_r >> 1;
        end
      end
      wts_pkg::S_VAR_SQ: begin
        if (mp_r != '0) begin
          if (mp_r[0]) acc_r <= addsub;
          mc_r <= mc_r << 1;
          mp_r <= mp_r >> 1;
        end
      end
      wts_pkg::S_SQRT: begin
        if (sqrt_sts.done) dev_r <= wts_pkg::sat_out(wts_pkg::DIV_W'(sq_root));
      end
      wts_pkg::S_DONE: begin
        if (out_free) begin
          out_status_r  <= status_r;
          out_entries_r <= cnt_r;
          out_fill_r    <= cur_fill;
          out_mean_r    <= mean_r;
          out_dev_r     <= dev_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_entries_counted = out_entries_r;
  assign out_fill_level      = out_fill_r;
  assign out_mean_bytes      = out_mean_r;
  assign out_deviation_bytes = out_dev_r;

  // rings never hold more than their depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= wts_pkg::FILL_W'(wts_pkg::RING_DEPTH) &&
    fill_r[1] <= wts_pkg::FILL_W'(wts_pkg::RING_DEPTH))
    else $error("ring fill above depth");

  // divider only finishes while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == wts_pkg::S_MEAN_WAIT || state_r == wts_pkg::S_VAR_WAIT))
    else $error("divider done outside wait state");

  // square root only finishes in its wait state
  a_sqrt_done: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_sts.done |-> state_r == wts_pkg::S_SQRT)
    else $error("sqrt done outside wait state");

  // an accepted word always starts execution next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == wts_pkg::S_EXEC)
    else $error("accepted word not executed");

endmodule
`default_nettype wire

// ----- test/windowed_transfer_statistics_tb.sv -----
`timescale 1ns / 1ps
module windowed_transfer_statistics_tb;

  // opcode 3 is not defined by the block but must be answered as a no-op
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
  localparam int DRAIN_CYCLES = 600;

  typedef struct packed {
    logic [1:0]                 status;
    logic [wts_pkg::FILL_W-1:0] counted;
    logic [wts_pkg::FILL_W-1:0] fill;
    logic [wts_pkg::OUT_W-1:0]  mean;
    logic [wts_pkg::OUT_W-1:0]  dev;
  } stat_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = wts_pkg::OP_ADD;
  logic in_direction = 1'b0;
  logic [31:0] in_now_seconds = '0;
  logic [31:0] in_byte_count = '0;
  logic [31:0] in_window_seconds = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [wts_pkg::FILL_W-1:0] out_entries_counted;
  logic [wts_pkg::FILL_W-1:0] out_fill_level;
  logic [wts_pkg::OUT_W-1:0] out_mean_bytes;
  logic [wts_pkg::OUT_W-1:0] out_deviation_bytes;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  windowed_transfer_statistics u_dut (.*);

  // shadow copy of both mark rings
  logic [31:0] mark_ts [2][wts_pkg::RING_DEPTH];
  logic [31:0] mark_cnt [2][wts_pkg::RING_DEPTH];
  logic [wts_pkg::IDX_W-1:0] ring_oldest [2];
  logic [wts_pkg::FILL_W-1:0] ring_fill [2];

  stat_word_t pending_words[$];
  int mismatches = 0;
  int words_checked = 0;
  int items_sent = 0;
  int drop_words = 0;
  bit no_gaps = 1'b0;     // burst stretches with no sender idling
  bit no_stalls = 1'b0;   // stretches with the receiver always ready
  logic [31:0] ring_time [2];

  function automatic logic [31:0] mark_age(logic [31:0] now, logic [31:0] ts);
    return (now >= ts) ? now - ts : 32'd0;
  endfunction

  function automatic logic [wts_pkg::OUT_W-1:0] clip40(logic [127:0] v);
    return (v > MAX40) ? MAX40 : v[wts_pkg::OUT_W-1:0];
  endfunction

  // advances the shadow rings and returns the word the block should produce
  function automatic stat_word_t predict_word(logic [1:0] op, logic dir, logic [31:0] now,
                                              logic [31:0] nbytes, logic [31:0] win);
    stat_word_t w;
    logic [wts_pkg::IDX_W-1:0] slot;
    int k;
    logic [127:0] s1, s2, num, den, q, root, cand;
    w = '0;
    case (op)
      wts_pkg::OP_ADD: begin
        if (ring_fill[dir] >= wts_pkg::RING_DEPTH) begin
          ring_oldest[dir] = ring_oldest[dir] + 1'b1;
          ring_fill[dir] = wts_pkg::FILL_W'(wts_pkg::RING_DEPTH - 1);
          w.status = wts_pkg::STS_DROPPED;
        end
        slot = ring_oldest[dir] + ring_fill[dir][wts_pkg::IDX_W-1:0];
        mark_ts[dir][slot] = now;
        mark_cnt[dir][slot] = nbytes;
        ring_fill[dir] = ring_fill[dir] + 1'b1;
      end
      wts_pkg::OP_CLEAN: begin
        k = 0;
        if (win == 0) k = int'(ring_fill[dir]);
        else
          while (k < ring_fill[dir] &&
                 mark_age(now, mark_ts[dir][wts_pkg::IDX_W'(ring_oldest[dir] + k)]) >= win)
            k++;
        ring_oldest[dir] = ring_oldest[dir] + wts_pkg::IDX_W'(k);
        ring_fill[dir] = ring_fill[dir] - wts_pkg::FILL_W'(k);
        w.counted = wts_pkg::FILL_W'(k);
      end
      wts_pkg::OP_STATS: begin
        if (win == 0) w.status = wts_pkg::STS_ZERO_WIN;
        else begin
          k = 0;
          s1 = '0;
          s2 = '0;
          // walk from the newest mark back while it stays inside the window
          while (k < ring_fill[dir]) begin
            slot = wts_pkg::IDX_W'(ring_oldest[dir] + ring_fill[dir] - 1 - k);
            if (mark_age(now, mark_ts[dir][slot]) > win) break;
            s1 += mark_cnt[dir][slot];
            s2 += 128'(mark_cnt[dir][slot]) * 128'(mark_cnt[dir][slot]);
            k++;
          end
          w.counted = wts_pkg::FILL_W'(k);
          if (k > 0) w.mean = clip40((s1 << wts_pkg::FRAC_BITS) / k);
          if (k > 1) begin
            num = 128'(k) * s2 - s1 * s1;
            den = 128'(k) * 128'(k - 1);
            q = (num << (2 * wts_pkg::FRAC_BITS)) / den;
            root = '0;
            for (int b = 63; b >= 0; b--) begin
              cand = root | (128'd1 << b);
              if (cand * cand <= q) root = cand;
            end
            w.dev = clip40(root);
          end
        end
      end
      default: ;
    endcase
    w.fill = ring_fill[dir];
    return w;
  endfunction

  // one word per call; gap is the idle time drawn before presenting it
  task automatic send_word(logic [1:0] op, logic dir, logic [31:0] now,
                           logic [31:0] nbytes, logic [31:0] win);
    int gap;
    stat_word_t expected;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_opcode = op;
    in_direction = dir;
    in_now_seconds = now;
    in_byte_count = nbytes;
    in_window_seconds = win;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected = predict_word(op, dir, now, nbytes, win);
    pending_words = {pending_words, expected};
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // receiver side: random stall before taking each word
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = no_stalls ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare every accepted word with the oldest expectation
  always @(posedge clk) begin
    stat_word_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_entries_counted, out_fill_level, out_mean_bytes,
              out_deviation_bytes};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (want.status == wts_pkg::STS_DROPPED) drop_words++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d counted %0d/%0d fill %0d/%0d mean %h/%h dev %h/%h",
                     want.status, got.status, want.counted, got.counted, want.fill, got.fill,
                     want.mean, got.mean, want.dev, got.dev);
        end
      end
    end
  end

  // hand-picked corners: empty rings, zero windows, single mark, future stamps
  task automatic test_directed();
    send_word(wts_pkg::OP_STATS, 1'b0, 32'd100, 32'd0, 32'd10);
    send_word(wts_pkg::OP_STATS, 1'b0, 32'd100, 32'd0, 32'd0);
    send_word(wts_pkg::OP_CLEAN, 1'b1, 32'd100, 32'd0, 32'd5);
    send_word(OP_UNUSED, 1'b1, '1, '1, '1);
    send_word(wts_pkg::OP_ADD, 1'b0, 32'd100, 32'd0, '1);
    send_word(wts_pkg::OP_STATS, 1'b0, 32'd100, 32'd0, 32'd1);
    send_word(wts_pkg::OP_ADD, 1'b0, 32'd101, '1, 32'd0);
    send_word(wts_pkg::OP_STATS, 1'b0, 32'd101, 32'd0, 32'd1);
    send_word(wts_pkg::OP_ADD, 1'b0, 32'd200, 32'd12345, 32'd0);
    // mark stamped after now counts as age zero
    send_word(wts_pkg::OP_STATS, 1'b0, 32'd150, 32'd0, 32'd60);
    send_word(wts_pkg::OP_STATS, 1'b0, 32'd200, 32'd0, '1);
    send_word(OP_UNUSED, 1'b0, 32'd0, 32'd0, 32'd0);
    // nothing old enough to clean
    send_word(wts_pkg::OP_CLEAN, 1'b0, 32'd200, 32'd0, 32'd500);
    send_word(wts_pkg::OP_CLEAN, 1'b0, 32'd201, 32'd0, 32'd100);
    send_word(wts_pkg::OP_STATS, 1'b0, 32'd201, 32'd0, 32'd100);
    send_word(wts_pkg::OP_ADD, 1'b1, '1, '1, 32'd0);
    send_word(wts_pkg::OP_ADD, 1'b1, '1, 32'd1, 32'd0);
    send_word(wts_pkg::OP_STATS, 1'b1, '1, 32'd0, 32'd1);
    send_word(wts_pkg::OP_CLEAN, 1'b1, '1, 32'd0, 32'd0);
    send_word(wts_pkg::OP_CLEAN, 1'b0, 32'd0, 32'd0, 32'd0);
    send_word(wts_pkg::OP_STATS, 1'b1, '1, 32'd0, '1);
    wait_drained();
  endtask

  // overfill one ring so the oldest marks are dropped, then take statistics around a clean
  task automatic test_ring_overflow();
    no_gaps = 1'b1;
    for (int i = 0; i < wts_pkg::RING_DEPTH + 6; i++)
      send_word(wts_pkg::OP_ADD, 1'b1, 32'(1000 + i), (i % 3 == 0) ? '1 : $urandom, 32'd0);
    no_gaps = 1'b0;
    send_word(wts_pkg::OP_STATS, 1'b1, 32'd1100, 32'd0, '1);
    send_word(wts_pkg::OP_STATS, 1'b1, 32'd1100, 32'd0, 32'd50);
    send_word(wts_pkg::OP_CLEAN, 1'b1, 32'd1100, 32'd0, 32'd80);
    send_word(wts_pkg::OP_STATS, 1'b1, 32'd1100, 32'd0, 32'd1000);
    wait_drained();
  endtask

  function automatic logic [31:0] draw_bytes();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1000);
      1: return '1 - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] draw_window();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom;
      2: return '1;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  // mostly time-ordered traffic per ring, with some fully random words mixed in
  task automatic test_random(int count);
    logic dir;
    int pick;
    ring_time[0] = $urandom;
    ring_time[1] = $urandom;
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        no_gaps = ($urandom_range(0, 2) == 0);
        no_stalls = ($urandom_range(0, 2) == 0);
      end
      dir = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 10)
        send_word(2'($urandom), dir, $urandom, $urandom, $urandom);
      else if (pick < 65) begin
        ring_time[dir] += $urandom_range(0, 4);
        send_word(wts_pkg::OP_ADD, dir, ring_time[dir], draw_bytes(), $urandom);
      end else if (pick < 78)
        send_word(wts_pkg::OP_CLEAN, dir, ring_time[dir], $urandom, draw_window());
      else
        send_word(wts_pkg::OP_STATS, dir, ring_time[dir], $urandom, draw_window());
      // quiet the sender once midway until the block has answered everything
      if (i == count / 2) wait_drained();
    end
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    wait_drained();
  endtask

  initial begin
    for (int d = 0; d < 2; d++) begin
      ring_oldest[d] = '0;
      ring_fill[d] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_ring_overflow();
    test_random(460);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d words, checked %0d results (%0d with a dropped mark), %0d mismatches",
             items_sent, words_checked, drop_words, mismatches);
    $display("covered add, clean, statistics and unused opcodes on both rings");
    if (mismatches == 0 && pending_words.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", pending_words.size());
    $display("Verification failed");
    $finish;
  end

endmodule
